// ----- rtl/pfa_pkg.sv -----
// Shared types, constants and helpers for the packed field array.
package pfa_pkg;

  localparam int WORD_BITS       = 32;
  localparam int SHIFT_W         = 5;
  localparam int STORE_WORDS_DEF = 1024;
  localparam int IDX_W           = 15;
  localparam int CFG_W           = 6;
  localparam int START_W         = IDX_W + CFG_W;

  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_CHECK,
    ST_RD_HI,
    ST_CAP_HI,
    ST_WR_LO,
    ST_WR_HI,
    ST_RESP
  } pfa_state_t;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic calc;
    logic rd_lo;
    logic cap_lo;
    logic rd_hi;
    logic cap_hi;
    logic wr_lo;
    logic wr_hi;
    logic load_out;
  } pfa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic oor;
    logic straddle;
    logic is_write;
    logic out_free;
  } pfa_sts_t;

  // Width 0 acts as 1, anything above 32 saturates.
  function automatic logic [CFG_W-1:0] eff_width(input logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] r;
    if (w == '0) begin
      r = CFG_W'(1);
    end else if (w > CFG_W'(WORD_BITS)) begin
      r = CFG_W'(WORD_BITS);
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ----- rtl/pfa_ram.sv -----
// Generic simple dual-port RAM with registered read.
module pfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pfa_ctrl.sv -----
// Sequencer for the packed field array: clear sweep and per-request steps.
module pfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfa_pkg::pfa_sts_t sts,
  output pfa_pkg::pfa_cmd_t cmd
);
  import pfa_pkg::*;

  pfa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts.oor) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.rd_lo = 1'b1;
          state_nxt = ST_RD_HI;
        end
      end
      ST_RD_HI: begin
        cmd.cap_lo = 1'b1;
        cmd.rd_hi  = 1'b1;
        state_nxt  = ST_CAP_HI;
      end
      ST_CAP_HI: begin
        cmd.cap_hi = 1'b1;
        state_nxt  = sts.is_write ? ST_WR_LO : ST_RESP;
      end
      ST_WR_LO: begin
        cmd.wr_lo = 1'b1;
        state_nxt = sts.straddle ? ST_WR_HI : ST_RESP;
      end
      ST_WR_HI: begin
        cmd.wr_hi = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/pfa_dp.sv -----
// Datapath: width register, address math, word store, bit-field extract/insert.
module pfa_dp #(
  parameter int STORE_WORDS = pfa_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfa_pkg::pfa_cmd_t             cmd,
  output pfa_pkg::pfa_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_func,
  input  logic [pfa_pkg::IDX_W-1:0]     in_elem_index,
  input  logic [pfa_pkg::WORD_BITS-1:0] in_write_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::WORD_BITS-1:0] out_read_value,
  output logic                          out_is_nonzero,
  output logic                          out_out_of_range
);
  import pfa_pkg::*;

  localparam int AW = $clog2(STORE_WORDS);
  localparam logic [63:0] TOTAL_BITS = 64'(STORE_WORDS) * 64'(WORD_BITS);

  logic [CFG_W-1:0]     width_r;
  logic                 func_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WORD_BITS-1:0] val_r;
  logic [START_W-1:0]   start_r;
  logic [WORD_BITS-1:0] lo_r, hi_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_value_r;
  logic                 out_nz_r, out_oor_r;

  logic [CFG_W-1:0]     w_eff;
  logic [START_W:0]     end_bits;
  logic                 oor;
  logic [SHIFT_W-1:0]   shift;
  logic                 straddle;
  logic [AW-1:0]        cid, cid_nxt;
  logic [WORD_BITS-1:0] mask32, elem, wval;
  logic [2*WORD_BITS-1:0] window, mask64, new_win;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign w_eff    = eff_width(width_r);
  assign end_bits = {1'b0, start_r} + (START_W+1)'(w_eff);
  assign oor      = 64'(end_bits) > TOTAL_BITS;
  assign shift    = start_r[SHIFT_W-1:0];
  assign straddle = ({2'b00, shift} + {1'b0, w_eff}) > 7'(WORD_BITS);
  assign cid      = AW'(start_r >> SHIFT_W);
  assign cid_nxt  = cid + AW'(1);

  assign mask32  = (w_eff == CFG_W'(WORD_BITS)) ? '1
                 : ((WORD_BITS'(1) << w_eff[SHIFT_W-1:0]) - WORD_BITS'(1));
  assign window  = {hi_r, lo_r};
  assign elem    = window[shift +: WORD_BITS] & mask32;
  assign wval    = (w_eff == CFG_W'(1)) ? WORD_BITS'(|val_r) : (val_r & mask32);
  assign mask64  = {{WORD_BITS{1'b0}}, mask32} << shift;
  assign new_win = (window & ~mask64) | ({{WORD_BITS{1'b0}}, wval} << shift);

  // Write port: clear sweep or the two halves of a read-modify-write.
  always_comb begin
    ram_we    = cmd.clr_wr | cmd.wr_lo | cmd.wr_hi;
    ram_waddr = cid;
    ram_wdata = new_win[WORD_BITS-1:0];
    if (cmd.clr_wr) begin
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (cmd.wr_hi) begin
      ram_waddr = cid_nxt;
      ram_wdata = new_win[2*WORD_BITS-1:WORD_BITS];
    end
  end

  assign ram_re    = cmd.rd_lo | cmd.rd_hi;
  assign ram_raddr = cmd.rd_hi ? cid_nxt : cid;

  pfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= CFG_W'(1);
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_r <= cfg_data;
      end
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r <= in_func;
      idx_r  <= in_elem_index;
      val_r  <= in_write_value;
    end
    if (cmd.calc) begin
      start_r <= START_W'(idx_r) * START_W'(w_eff);
    end
    if (cmd.cap_lo) begin
      lo_r <= ram_rdata;
    end
    if (cmd.cap_hi) begin
      hi_r <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_value_r <= (func_r == FUNC_READ && !oor) ? elem : '0;
      out_nz_r    <= (func_r == FUNC_READ && !oor) && (elem != '0);
      out_oor_r   <= oor;
    end
  end

  assign sts.clear_last = (clr_cnt_r == AW'(STORE_WORDS - 1));
  assign sts.oor        = oor;
  assign sts.straddle   = straddle;
  assign sts.is_write   = (func_r == FUNC_WRITE);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_read_value   = out_value_r;
  assign out_is_nonzero   = out_nz_r;
  assign out_out_of_range = out_oor_r;

endmodule

// ----- rtl/packed_field_array.sv -----
// Top level of the packed field array: bit-packed element store with read/write requests.
//
// A store of STORE_WORDS 32-bit words holds elements of cfg_element_width bits
// (0 acts as 1, above 32 saturates to 32), element n at bit n*width, possibly
// straddling two words. A read request returns the element and a nonzero flag;
// a write request replaces only that element's bits (width 1: any nonzero value
// writes a 1), reading and rewriting both words of a straddle. Requests whose
// element runs past the end of the store return out_of_range with zero data and
// leave the store alone. After reset the block sweeps the store to zero, one
// word per cycle, through all STORE_WORDS words (1024 by default); no request is
// taken during the sweep. A request then occupies the single sequencer through
// the index multiply, the range check, two registered reads of the word RAM
// (skipped when out of range) and, for a write, one RAM write per word touched.
// The result sits in an output register, so the next request is taken while an
// earlier result waits. Change the width only while no request is outstanding.
module packed_field_array #(
  parameter int STORE_WORDS = pfa_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfa_pkg::CFG_W-1:0]     cfg_element_width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [pfa_pkg::IDX_W-1:0]     in_elem_index,
  input  logic [pfa_pkg::WORD_BITS-1:0] in_write_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pfa_pkg::WORD_BITS-1:0] out_read_value,
  output logic                          out_is_nonzero,
  output logic                          out_out_of_range
);
  import pfa_pkg::*;

  pfa_cmd_t cmd;
  pfa_sts_t sts;

  // Width register always takes writes.
  assign cfg_ready = 1'b1;

  pfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pfa_dp #(
    .STORE_WORDS (STORE_WORDS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid),
    .cfg_data         (cfg_element_width),
    .in_func          (in_func),
    .in_elem_index    (in_elem_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_is_nonzero   (out_is_nonzero),
    .out_out_of_range (out_out_of_range)
  );

endmodule

// ----- sim/packed_field_array_test.sv -----
// Self-checking testbench for packed_field_array: request driver, result monitor, shadow store.
module packed_field_array_test;

  import pfa_pkg::*;

  localparam int STORE_WORDS = STORE_WORDS_DEF;
  localparam int TOTAL_BITS  = STORE_WORDS * WORD_BITS;
  localparam int MAX_INDEX   = (1 << IDX_W) - 1;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic                 func;
    logic [IDX_W-1:0]     index;
    logic [WORD_BITS-1:0] value;
  } elem_req_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] read_value;
    logic                 is_nonzero;
    logic                 out_of_range;
  } elem_result_t;

  typedef struct packed {
    elem_req_t    req;
    elem_result_t res;
  } elem_expect_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_element_width = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_func = FUNC_READ;
  logic [IDX_W-1:0]     in_elem_index = '0;
  logic [WORD_BITS-1:0] in_write_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_BITS-1:0] out_read_value;
  logic                 out_is_nonzero;
  logic                 out_out_of_range;

  packed_field_array dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_element_width(cfg_element_width),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_elem_index    (in_elem_index),
    .in_write_value   (in_write_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_value   (out_read_value),
    .out_is_nonzero   (out_is_nonzero),
    .out_out_of_range (out_out_of_range)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the word store and of the width register.
  logic [WORD_BITS-1:0] shadow_words [STORE_WORDS];
  logic [CFG_W-1:0]     width_model = CFG_W'(1);

  elem_req_t    req_backlog[$];
  elem_expect_t pending_results[$];

  int  reqs_queued   = 0;
  int  reqs_accepted = 0;
  int  fault_count   = 0;
  int  send_idle_pct = 0;
  int  stall_pct     = 0;
  int  hold_trig     = 0;
  int  hold_seen     = 0;
  int  hold_left     = 0;
  logic req_fire     = 1'b0;

  initial begin
    foreach (shadow_words[i]) shadow_words[i] = '0;
  end

  // Width 0 behaves as 1, anything above 32 as 32.
  function automatic int unsigned active_width(input logic [CFG_W-1:0] w);
    if (w == '0) return 1;
    if (w > CFG_W'(WORD_BITS)) return WORD_BITS;
    return 32'(w);
  endfunction

  // Apply one request to the shadow store and return what the block should answer.
  function automatic elem_result_t apply_request(input elem_req_t r);
    int unsigned  w, start, cid, sh;
    logic         straddle;
    logic [63:0]  window, mask, v;
    elem_result_t res;
    res   = '0;
    w     = active_width(width_model);
    start = r.index * w;
    if (start + w > TOTAL_BITS) begin
      res.out_of_range = 1'b1;
      return res;
    end
    cid      = start / WORD_BITS;
    sh       = start % WORD_BITS;
    straddle = (sh + w) > WORD_BITS;
    window   = {32'h0, shadow_words[cid]};
    if (straddle) window[63:32] = shadow_words[cid + 1];
    mask = (64'd1 << w) - 64'd1;
    if (r.func == FUNC_READ) begin
      v = (window >> sh) & mask;
      res.read_value = v[31:0];
      res.is_nonzero = (v != 0);
    end else begin
      // a one-bit element stores any nonzero value as 1
      v = (w == 1) ? 64'(r.value != 0) : ({32'h0, r.value} & mask);
      window = (window & ~(mask << sh)) | (v << sh);
      shadow_words[cid] = window[31:0];
      if (straddle) shadow_words[cid + 1] = window[63:32];
    end
    return res;
  endfunction

  // Request driver: offers the next backlog entry unless it decides to idle.
  always @(negedge clk) begin : drive_requests
    elem_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_fire) begin
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = req_backlog.pop_front();
        in_valid       <= 1'b1;
        in_func        <= nxt.func;
        in_elem_index  <= nxt.index;
        in_write_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus a long hold whenever one is triggered.
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_trig != hold_seen) begin
      hold_seen <= hold_trig;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted result in order.
  always @(posedge clk) begin : observe
    elem_result_t got;
    elem_expect_t want;
    if (!rst_n) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        want.req = '{in_func, in_elem_index, in_write_value};
        want.res = apply_request(want.req);
        pending_results.push_back(want);
        reqs_accepted++;
      end
      if (out_valid && out_ready) begin
        got = '{out_read_value, out_is_nonzero, out_out_of_range};
        if (pending_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("unexpected result: data %h nz %b oor %b",
                     got.read_value, got.is_nonzero, got.out_of_range);
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.res.read_value ||
              got.is_nonzero !== want.res.is_nonzero ||
              got.out_of_range !== want.res.out_of_range) begin
            fault_count++;
            if (fault_count <= 10)
              $display("mismatch func %b idx %0d width %0d: exp %h/%b/%b got %h/%b/%b",
                       want.req.func, want.req.index, active_width(width_model),
                       want.res.read_value, want.res.is_nonzero, want.res.out_of_range,
                       got.read_value, got.is_nonzero, got.out_of_range);
          end
        end
      end
    end
  end

  task automatic queue_request(input logic f, input int unsigned idx,
                               input logic [WORD_BITS-1:0] val);
    req_backlog.push_back('{f, IDX_W'(idx), val});
    reqs_queued++;
  endtask

  // Every request answers exactly once, so matching counts mean the block is idle.
  task automatic wait_drained();
    do @(negedge clk);
    while (reqs_accepted != reqs_queued || pending_results.size() != 0);
  endtask

  task automatic write_width(input logic [CFG_W-1:0] w);
    @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_element_width <= w;
    do @(posedge clk);
    while (!cfg_ready);
    width_model = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly in-range indexes clustered in a hot window so reads hit earlier writes;
  // some near the end of the store and a few anywhere in the index space.
  task automatic push_random(input int n);
    int unsigned top, hot, idx, pick;
    logic [WORD_BITS-1:0] val;
    logic f;
    top = TOTAL_BITS / active_width(width_model) - 1;
    if (top > MAX_INDEX) top = MAX_INDEX;
    hot = $urandom_range(top - 63);
    while (n > 0) begin
      pick = $urandom_range(99);
      if (pick < 55)      idx = hot + $urandom_range(63);
      else if (pick < 80) idx = $urandom_range(top);
      else if (pick < 90) idx = top - 2 + $urandom_range(4);
      else                idx = $urandom_range(MAX_INDEX);
      if (idx > MAX_INDEX) idx = MAX_INDEX;
      pick = $urandom_range(9);
      val = (pick == 0) ? '0 : (pick == 1) ? '1 : (pick == 2) ? 32'd1 : $urandom;
      f = 1'($urandom_range(1));
      queue_request(f, idx, val);
      n--;
      // write followed by a read of the same element
      if (f == FUNC_WRITE && $urandom_range(99) < 40 && n > 0) begin
        queue_request(FUNC_READ, idx, $urandom);
        n--;
      end
    end
  endtask

  initial begin : stimulus
    int send_opts[3];
    int stall_opts[3];
    send_opts  = '{0, 12, 0};
    stall_opts = '{88, 12, 0};
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // width 1: both ends of the index space, nonzero write collapses to 1
    write_width(CFG_W'(1));
    queue_request(FUNC_WRITE, 0, 32'h8000_0000);
    queue_request(FUNC_READ, 0, '0);
    queue_request(FUNC_WRITE, MAX_INDEX, 32'd1);
    queue_request(FUNC_READ, MAX_INDEX, '1);
    queue_request(FUNC_WRITE, MAX_INDEX, '0);
    queue_request(FUNC_READ, MAX_INDEX, '0);
    push_random(100);
    wait_drained();
    // sender paused until everything came back, now resume
    push_random(100);
    wait_drained();

    // width 32: last word in range, first out of range
    send_idle_pct = 88;
    write_width(CFG_W'(32));
    queue_request(FUNC_WRITE, STORE_WORDS - 1, '1);
    queue_request(FUNC_READ, STORE_WORDS - 1, '0);
    queue_request(FUNC_READ, STORE_WORDS, '0);
    queue_request(FUNC_WRITE, STORE_WORDS, '1);
    queue_request(FUNC_READ, MAX_INDEX, '0);
    push_random(200);
    wait_drained();

    // width 7: straddling element and its neighbors, top of store
    send_idle_pct = 0;
    stall_pct     = 88;
    write_width(CFG_W'(7));
    queue_request(FUNC_WRITE, 4, '1);
    queue_request(FUNC_READ, 4, '0);
    queue_request(FUNC_READ, 3, '0);
    queue_request(FUNC_READ, 5, '0);
    queue_request(FUNC_WRITE, TOTAL_BITS / 7 - 1, 32'h55);
    queue_request(FUNC_READ, TOTAL_BITS / 7, '0);
    push_random(200);
    wait_drained();

    // width 0 acts as 1
    send_idle_pct = 12;
    stall_pct     = 12;
    write_width(CFG_W'(0));
    queue_request(FUNC_WRITE, 1, 32'd2);
    queue_request(FUNC_READ, 1, '0);
    push_random(200);
    wait_drained();

    // width 63 saturates to 32; long output stall with the sender running flat out
    send_idle_pct = 0;
    stall_pct     = 0;
    write_width(CFG_W'(63));
    queue_request(FUNC_WRITE, 0, 32'h1234_5678);
    queue_request(FUNC_READ, 0, '0);
    hold_trig++;
    push_random(200);
    wait_drained();

    send_idle_pct = 88;
    write_width(CFG_W'(33));
    push_random(150);
    wait_drained();

    for (int k = 0; k < 3; k++) begin
      send_idle_pct = send_opts[k];
      stall_pct     = stall_opts[k];
      write_width(CFG_W'($urandom_range(2, 31)));
      push_random(200);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    fault_count += pending_results.size();
    if (fault_count == 0) begin
      $display("PASS packed_field_array");
    end else begin
      $display("FAIL packed_field_array");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL packed_field_array");
    $finish;
  end

endmodule
